// ===== hdl/lodc_pkg.sv =====
package lodc_pkg;

  // input word: one acquire or release
  typedef struct packed {
    logic       mode;
    logic [4:0] lock_id;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0] status;
    logic [4:0] held_count;
  } out_word_t;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_DEADLOCK    = 3'd1,
    STS_REL_EMPTY   = 3'd2,
    STS_REL_NOT_TOP = 3'd3,
    STS_OVERFLOW    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_EDGE,
    S_WALK,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    add_edge;
    logic    walk_step;
    logic    walk_end;
    logic    undo_edge;
    logic    commit;
    act_t    act;
    status_t sts;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_release;
    logic ptr_zero;
    logic ptr_full;
    logic top_eq;
    logic edge_ok;
    logic edge_known;
    logic walk_done;
    logic cycle;
  } dp_sts_t;

endpackage

// ===== hdl/lodc_ctrl.sv =====
module lodc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lodc_pkg::dp_cmd_t cmd,
  input  lodc_pkg::dp_sts_t sts
);

  lodc_pkg::state_t  state_r, state_nxt;
  lodc_pkg::status_t res_r, res_nxt;
  lodc_pkg::act_t    act_r, act_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != lodc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // state and decision registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lodc_pkg::S_IDLE;
      res_r       <= lodc_pkg::STS_OK;
      act_r       <= lodc_pkg::ACT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.act       = act_r;
    cmd.sts       = res_r;

    // result word leaves when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lodc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = lodc_pkg::S_LOAD;
        end
      end
      lodc_pkg::S_LOAD: begin
        state_nxt = lodc_pkg::S_FINISH;
        if (sts.is_release) begin
          if (sts.ptr_zero) begin
            res_nxt = lodc_pkg::STS_REL_EMPTY;
            act_nxt = lodc_pkg::ACT_NONE;
          end else if (!sts.top_eq) begin
            res_nxt = lodc_pkg::STS_REL_NOT_TOP;
            act_nxt = lodc_pkg::ACT_NONE;
          end else begin
            res_nxt = lodc_pkg::STS_OK;
            act_nxt = lodc_pkg::ACT_POP;
          end
        end else if (!sts.ptr_zero && !sts.top_eq && sts.edge_ok) begin
          state_nxt = lodc_pkg::S_EDGE;
        end else if (sts.ptr_full) begin
          res_nxt = lodc_pkg::STS_OVERFLOW;
          act_nxt = lodc_pkg::ACT_NONE;
        end else begin
          res_nxt = lodc_pkg::STS_OK;
          act_nxt = lodc_pkg::ACT_PUSH;
        end
      end
      lodc_pkg::S_EDGE: begin
        if (sts.edge_known) begin
          state_nxt = lodc_pkg::S_FINISH;
          res_nxt   = sts.ptr_full ? lodc_pkg::STS_OVERFLOW : lodc_pkg::STS_OK;
          act_nxt   = sts.ptr_full ? lodc_pkg::ACT_NONE : lodc_pkg::ACT_PUSH;
        end else begin
          cmd.add_edge = 1'b1;
          state_nxt    = lodc_pkg::S_WALK;
        end
      end
      lodc_pkg::S_WALK: begin
        if (sts.walk_done) begin
          cmd.walk_end = 1'b1;
          state_nxt    = lodc_pkg::S_FINISH;
          if (sts.cycle) begin
            cmd.undo_edge = 1'b1;
            res_nxt       = lodc_pkg::STS_DEADLOCK;
            act_nxt       = lodc_pkg::ACT_NONE;
          end else begin
            res_nxt = sts.ptr_full ? lodc_pkg::STS_OVERFLOW : lodc_pkg::STS_OK;
            act_nxt = sts.ptr_full ? lodc_pkg::ACT_NONE : lodc_pkg::ACT_PUSH;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      lodc_pkg::S_FINISH: begin
        // wait for a free output register, then commit and emit
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lodc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lodc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lodc_dp.sv =====
module lodc_dp #(
  parameter int MAX_LOCKS   = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lodc_pkg::in_word_t  in_word,
  output lodc_pkg::out_word_t out_word,
  input  lodc_pkg::dp_cmd_t   cmd,
  output lodc_pkg::dp_sts_t   sts
);

  localparam int LW = $clog2(MAX_LOCKS);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  // edge matrix: one row per source lock, valid bit per row
  logic [MAX_LOCKS-1:0] row_mem [MAX_LOCKS];
  logic [MAX_LOCKS-1:0] row_vld_r;
  logic [MAX_LOCKS-1:0] row_q;
  logic                 row_vld_q;

  // held-lock stack
  logic [4:0]           stk_mem [STACK_DEPTH];
  logic [4:0]           top_q;
  logic [PW-1:0]        ptr_r, ptr_nxt;

  lodc_pkg::in_word_t   item_r;
  lodc_pkg::out_word_t  out_word_r;

  // walk state
  logic [MAX_LOCKS-1:0] seen_r, done_r, edge_row_r;
  logic                 pend_r;

  logic [MAX_LOCKS-1:0] row_cur, seen_now, cand, id_bit, pick_bit;
  logic [LW-1:0]        top_idx, id_idx, pick, rd_addr;
  logic                 row_we;
  logic [MAX_LOCKS-1:0] row_wd;

  assign top_idx  = LW'(top_q);
  assign id_idx   = LW'(item_r.lock_id);
  assign id_bit   = MAX_LOCKS'(1) << id_idx;
  assign pick_bit = MAX_LOCKS'(1) << pick;

  assign row_cur  = row_vld_q ? row_q : '0;
  assign seen_now = seen_r | (pend_r ? row_cur : '0);
  assign cand     = seen_now & ~done_r;

  // lowest pending lock in the reached set
  always_comb begin
    pick = '0;
    for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = LW'(i);
      end
    end
  end

  assign rd_addr = cmd.walk_step ? pick : top_idx;
  assign row_we  = cmd.add_edge || cmd.undo_edge;
  assign row_wd  = cmd.add_edge ? (row_cur | id_bit) : edge_row_r;

  // status to controller
  assign sts.is_release = (item_r.mode == lodc_pkg::MODE_RELEASE);
  assign sts.ptr_zero   = (ptr_r == '0);
  assign sts.ptr_full   = (32'(ptr_r) >= STACK_DEPTH);
  assign sts.top_eq     = (top_q == item_r.lock_id);
  assign sts.edge_ok    = (32'(top_q) < MAX_LOCKS) && (32'(item_r.lock_id) < MAX_LOCKS);
  assign sts.edge_known = row_cur[id_idx];
  assign sts.walk_done  = (cand == '0);
  assign sts.cycle      = seen_now[top_idx];

  // edge matrix port: one write, one registered read
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[top_idx] <= row_wd;
    end
    row_q <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      row_vld_q <= 1'b0;
    end else begin
      if (row_we) begin
        row_vld_r[top_idx] <= 1'b1;
      end
      row_vld_q <= row_vld_r[rd_addr];
    end
  end

  // stack: top read every cycle, push on commit
  always_ff @(posedge clk) begin
    if (cmd.commit && (cmd.act == lodc_pkg::ACT_PUSH)) begin
      stk_mem[SW'(ptr_r)] <= item_r.lock_id;
    end
    top_q <= stk_mem[SW'(ptr_r - PW'(1))];
  end

  always_comb begin
    ptr_nxt = ptr_r;
    case (cmd.act)
      lodc_pkg::ACT_PUSH: ptr_nxt = ptr_r + PW'(1);
      lodc_pkg::ACT_POP:  ptr_nxt = ptr_r - PW'(1);
      default:            ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      seen_r <= '0;
    end else begin
      if (cmd.commit) begin
        ptr_r <= ptr_nxt;
      end
      if (cmd.add_edge) begin
        seen_r <= id_bit;
      end else if (cmd.walk_step || cmd.walk_end) begin
        seen_r <= seen_now;
      end
    end
  end

  // item, walk bookkeeping and result word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
    if (cmd.add_edge) begin
      edge_row_r <= row_cur;
      done_r     <= '0;
      pend_r     <= 1'b0;
    end else if (cmd.walk_step) begin
      done_r <= done_r | pick_bit;
      pend_r <= 1'b1;
    end
    if (cmd.commit) begin
      out_word_r.status     <= 3'(cmd.sts);
      out_word_r.held_count <= 5'(ptr_nxt);
    end
  end

  assign out_word = out_word_r;

endmodule

// ===== hdl/lock_order_deadlock_checker_core.sv =====
// Channel  Ports                          Word
// -------  -----------------------------  --------------------------------
// input    in_valid, in_stall, in_word    mode, lock_id
// result   out_valid, out_stall, out_word status, held_count
//
// One item at a time: a release, or an acquire on an empty stack or of the top
// lock, passes accept, decode and commit; any other acquire adds a row read in
// the edge state, and a new edge adds a walk that visits each reached row in turn
// and a closing step, all through the single read port of the edge matrix.
// Synchronous reset; edge matrix rows are cleared at once by row valid bits.
// The next item is taken while a result waits; its commit waits for a free slot.
module lock_order_deadlock_checker_core #(
  parameter int MAX_LOCKS   = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lodc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lodc_pkg::out_word_t out_word
);

  lodc_pkg::dp_cmd_t cmd;
  lodc_pkg::dp_sts_t sts;

  lodc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lodc_dp #(
    .MAX_LOCKS   (MAX_LOCKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: an accept closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  // stack count never beyond its depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_word.held_count) <= STACK_DEPTH))
    else $error("held count beyond stack depth");

  // release on empty leaves an empty stack
  a_empty_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == 3'(lodc_pkg::STS_REL_EMPTY)))
      |-> (out_word.held_count == '0))
    else $error("release on empty with nonzero count");

  // overflow only with a full stack
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == 3'(lodc_pkg::STS_OVERFLOW)))
      |-> (out_word.held_count == 5'(STACK_DEPTH)))
    else $error("overflow reported with a stack that is not full");
`endif

endmodule

// ===== test/lodc_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts each result word from the accepted input
// words and compares field by field in arrival order.
module lodc_result_checker
  import lodc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  output int unsigned words_in,
  output int unsigned pending_words,
  output int unsigned mismatches,
  output int unsigned deadlocks,
  output int unsigned overflows,
  output int unsigned refusals
);

  localparam int NUM_LOCKS  = 32;
  localparam int HELD_DEPTH = 16;

  // predicted lock-order graph and held stack
  logic [NUM_LOCKS-1:0] order_rows [NUM_LOCKS];
  logic [4:0]           held_ids   [HELD_DEPTH];
  int unsigned          held_depth;
  out_word_t            outcome_q  [$];

  initial begin
    words_in      = 0;
    pending_words = 0;
    mismatches    = 0;
    deadlocks     = 0;
    overflows     = 0;
    refusals      = 0;
    held_depth    = 0;
    for (int r = 0; r < NUM_LOCKS; r++) order_rows[r] = '0;
  end

  // closure of the order graph starting at one lock
  function automatic logic [NUM_LOCKS-1:0] reachable_from(input logic [4:0] start);
    logic [NUM_LOCKS-1:0] seen;
    logic [NUM_LOCKS-1:0] grown;
    seen = '0;
    seen[start] = 1'b1;
    for (int pass = 0; pass < NUM_LOCKS; pass++) begin
      grown = seen;
      for (int r = 0; r < NUM_LOCKS; r++) begin
        if (seen[r]) grown |= order_rows[r];
      end
      if (grown == seen) break;
      seen = grown;
    end
    return seen;
  endfunction

  // apply one word to the predicted state, return the expected result
  function automatic out_word_t predict_outcome(input in_word_t w);
    out_word_t            want;
    logic [4:0]           top;
    logic [NUM_LOCKS-1:0] reach;
    logic                 cycle;
    want.status = STS_OK;
    cycle = 1'b0;
    if (w.mode == MODE_ACQUIRE) begin
      if (held_depth > 0) begin
        top = held_ids[held_depth-1];
        if (top != w.lock_id && !order_rows[top][w.lock_id]) begin
          order_rows[top][w.lock_id] = 1'b1;
          reach = reachable_from(w.lock_id);
          if (reach[top]) begin
            order_rows[top][w.lock_id] = 1'b0;
            cycle = 1'b1;
          end
        end
      end
      if (cycle) begin
        want.status = STS_DEADLOCK;
      end else if (held_depth >= HELD_DEPTH) begin
        want.status = STS_OVERFLOW;
      end else begin
        held_ids[held_depth] = w.lock_id;
        held_depth++;
      end
    end else begin
      if (held_depth == 0) begin
        want.status = STS_REL_EMPTY;
      end else if (held_ids[held_depth-1] != w.lock_id) begin
        want.status = STS_REL_NOT_TOP;
      end else begin
        held_depth--;
      end
    end
    want.held_count = 5'(held_depth);
    return want;
  endfunction

  task automatic report_mismatch(input string what, input out_word_t got,
                                 input out_word_t want);
    $display("%0t ns: %s: status %0d held %0d, expected status %0d held %0d",
             $time, what, got.status, got.held_count, want.status, want.held_count);
    mismatches++;
  endtask

  // result side first (it belongs to older words), then the input side
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result word with nothing pending", out_word, '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_word.status !== want.status ||
              out_word.held_count !== want.held_count) begin
            report_mismatch("result word differs", out_word, want);
          end
          case (status_t'(want.status))
            STS_DEADLOCK:                   deadlocks++;
            STS_OVERFLOW:                   overflows++;
            STS_REL_EMPTY, STS_REL_NOT_TOP: refusals++;
            default: ;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        outcome_q.push_back(predict_outcome(in_word));
        words_in <= words_in + 1;
      end
      pending_words <= outcome_q.size();
    end
  end

endmodule

// ===== test/lock_order_deadlock_checker_core_tb.sv =====
`timescale 1ns / 100ps

module lock_order_deadlock_checker_core_tb;
  import lodc_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int unsigned words_in, pending_words, mismatches;
  int unsigned deadlocks, overflows, refusals;

  // idle percentages per side, changed between phases
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 58;

  // receiver hold-off bookkeeping
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // what the sender believes is held under the next sequence
  logic [4:0] held_guess [$];

  always #1 clk = ~clk;

  lock_order_deadlock_checker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  lodc_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .words_in      (words_in),
    .pending_words (pending_words),
    .mismatches    (mismatches),
    .deadlocks     (deadlocks),
    .overflows     (overflows),
    .refusals      (refusals)
  );

  // receiver: random stalls, plus one long hold-off while input keeps coming
  always @(posedge clk) begin
    if (!hold_done && words_in >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 240;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it; returns once accepted
  task automatic send_word(input logic mode, input logic [4:0] lock_id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{mode: mode, lock_id: lock_id};
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // mostly nested acquire/release sequences, some loose and broken words
  task automatic run_traffic(input int n_words);
    int         sent;
    int         pick;
    int         len;
    int         span;
    logic [4:0] id;
    logic [4:0] seq [$];
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_word(MODE_RELEASE, 5'($urandom_range(31)));
        sent++;
      end else if (pick < 12) begin
        id = 5'($urandom_range(31));
        send_word(MODE_ACQUIRE, id);
        if (held_guess.size() < 16) held_guess.push_back(id);
        sent++;
      end else if (pick < 18) begin
        if (held_guess.size() > 0) id = held_guess.pop_back();
        else id = 5'($urandom_range(31));
        send_word(MODE_RELEASE, id);
        sent++;
      end else begin
        len  = ($urandom_range(11) == 0) ? 17 : $urandom_range(1, 5);
        span = ($urandom_range(1) != 0) ? 7 : 31;
        seq.delete();
        for (int k = 0; k < len; k++) begin
          // now and then take the top lock again
          if (k > 0 && $urandom_range(7) == 0) id = seq[$];
          else id = 5'($urandom_range(span));
          seq.push_back(id);
          send_word(MODE_ACQUIRE, id);
        end
        while (seq.size() > 0) send_word(MODE_RELEASE, seq.pop_back());
        sent += 2 * len;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty release, reacquire, new and known edge, not-top, deadlock
    send_word(MODE_RELEASE, 5'd5);
    send_word(MODE_ACQUIRE, 5'd0);
    send_word(MODE_ACQUIRE, 5'd0);
    send_word(MODE_ACQUIRE, 5'd31);
    send_word(MODE_RELEASE, 5'd0);
    send_word(MODE_RELEASE, 5'd31);
    send_word(MODE_ACQUIRE, 5'd31);
    send_word(MODE_RELEASE, 5'd31);
    send_word(MODE_RELEASE, 5'd0);
    send_word(MODE_RELEASE, 5'd0);
    send_word(MODE_ACQUIRE, 5'd31);
    send_word(MODE_ACQUIRE, 5'd0);
    send_word(MODE_RELEASE, 5'd0);
    send_word(MODE_RELEASE, 5'd31);
    // full stack, one push too many, then drain
    repeat (17) send_word(MODE_ACQUIRE, 5'd21);
    repeat (16) send_word(MODE_RELEASE, 5'd21);

    run_traffic(300);
    wait_all_results();

    send_idle_pct <= 58;
    recv_idle_pct <= 35;
    run_traffic(300);
    wait_all_results();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_traffic(300);
    wait_all_results();
    repeat (40) @(posedge clk);

    $display("Run covered %0d words: %0d deadlocks, %0d overflows, %0d refused releases,",
             words_in, deadlocks, overflows, refusals);
    $display("under both idling mixes, a long output hold-off and full drains.");
    if (mismatches == 0) begin
      $display("PASS lock_order_deadlock_checker_core");
    end else begin
      $display("FAIL lock_order_deadlock_checker_core");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #1000000;
    $display("FAIL lock_order_deadlock_checker_core");
    $finish;
  end

endmodule

// ===== lock_order_deadlock_checker_core.f =====
hdl/lodc_pkg.sv
hdl/lodc_ctrl.sv
hdl/lodc_dp.sv
hdl/lock_order_deadlock_checker_core.sv
test/lodc_result_checker.sv
test/lock_order_deadlock_checker_core_tb.sv
